/* rtl/core/vfts_pkg.sv */
// Shared types and constants for the voxel field trilinear sampler.
// No dependencies; every other file in rtl/core refers to it by scoped names.
package vfts_pkg;

  // Q1.15 value of 1.0
  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // Width of a corner cell index (holds (z*dy+y)*dx+x for dims up to 127)
  localparam int CIW = 22;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    FS_SKY    = 2'd0,
    FS_WALL   = 2'd1,
    FS_INDOOR = 2'd2,
    FS_NONE   = 2'd3
  } fsel_e;

  typedef enum logic [1:0] {
    REG_DIM_X = 2'd0,
    REG_DIM_Y = 2'd1,
    REG_DIM_Z = 2'd2,
    REG_INV   = 2'd3
  } reg_e;

  // Step controls for the per-field interpolation datapath
  typedef struct packed {
    logic cap_even;  // latch an even corner
    logic x_en;      // x lerp of latched even corner and arriving odd corner
    logic y0_en;     // y lerp of the lower x pair
    logic y1_en;     // y lerp of the upper x pair
    logic z_en;      // final z lerp
  } lerp_ctl_t;

endpackage

/* rtl/core/vfts_mem.sv */
// Three field memories (sky view, wall permeability, indoorness), one write port
// and one shared read address with registered read data. Uses vfts_pkg.
module vfts_mem #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [1:0]    wsel_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [15:0]   wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [15:0]   rd_sky_o,
  output logic [15:0]   rd_wall_o,
  output logic [15:0]   rd_indoor_o
);

  logic [15:0] sky_mem    [DEPTH];
  logic [15:0] wall_mem   [DEPTH];
  logic [15:0] indoor_mem [DEPTH];

  // Write the selected field
  always_ff @(posedge clk_i) begin
    if (we_i && wsel_i == vfts_pkg::FS_SKY) begin
      sky_mem[waddr_i] <= wdata_i;
    end
    if (we_i && wsel_i == vfts_pkg::FS_WALL) begin
      wall_mem[waddr_i] <= wdata_i;
    end
    if (we_i && wsel_i == vfts_pkg::FS_INDOOR) begin
      indoor_mem[waddr_i] <= wdata_i;
    end
  end

  // Read all three fields every cycle
  always_ff @(posedge clk_i) begin
    rd_sky_o    <= sky_mem[raddr_i];
    rd_wall_o   <= wall_mem[raddr_i];
    rd_indoor_o <= indoor_mem[raddr_i];
  end

endmodule

/* rtl/core/vfts_lerp.sv */
// Interpolation datapath for one field: a shared rounded lerp unit stepped
// through four x, two y and one z lerps. Uses vfts_pkg::lerp_ctl_t.
module vfts_lerp (
  input  logic                clk_i,
  input  vfts_pkg::lerp_ctl_t ctl_i,
  input  logic [15:0]         din_i,
  input  logic                zero_i,
  input  logic [15:0]         fx_i,
  input  logic [15:0]         fy_i,
  input  logic [15:0]         fz_i,
  output logic [15:0]         res_o
);

  logic [15:0] din;
  logic [15:0] even_q;
  logic [15:0] xr_q [4];
  logic [15:0] yr0_q, yr1_q, res_q;
  logic [15:0] op_a, op_b, op_f;
  logic [33:0] sum;
  logic [15:0] mix;

  // Corners beyond storage read as zero
  assign din = zero_i ? 16'd0 : din_i;

  // Select operands for this step
  always_comb begin
    if (ctl_i.x_en) begin
      op_a = even_q;   op_b = din;      op_f = fx_i;
    end else if (ctl_i.y0_en) begin
      op_a = xr_q[0];  op_b = xr_q[1];  op_f = fy_i;
    end else if (ctl_i.y1_en) begin
      op_a = xr_q[2];  op_b = xr_q[3];  op_f = fy_i;
    end else begin
      op_a = yr0_q;    op_b = yr1_q;    op_f = fz_i;
    end
  end

  // a*(1-f) + b*f, rounded half up
  assign sum = 34'(op_a) * (34'd65536 - 34'(op_f)) + 34'(op_b) * 34'(op_f) + 34'd32768;
  assign mix = sum[31:16];

  // Advance the lerp chain
  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_even) begin
      even_q <= din;
    end
    if (ctl_i.x_en) begin
      xr_q[0] <= xr_q[1];
      xr_q[1] <= xr_q[2];
      xr_q[2] <= xr_q[3];
      xr_q[3] <= mix;
    end
    if (ctl_i.y0_en) begin
      yr0_q <= mix;
    end
    if (ctl_i.y1_en) begin
      yr1_q <= mix;
    end
    if (ctl_i.z_en) begin
      res_q <= mix;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/core/voxel_field_trilinear_sampler.sv */
// Top level of the voxel field trilinear sampler: control sequencer, APB registers,
// stream ports. Instantiates vfts_mem and vfts_lerp; uses vfts_pkg.
//
// One transaction is worked on at a time. A write gives no result. A linear read
// registers all three fields, then checks the index against the grid size.
// A sample runs each axis through the shared 32x24 position multiplier in turn, then
// does range check and base-index math, streams the eight corners out of the single
// read port of the field memories, runs 3 lerp steps and loads the output register;
// one outside the grid or on a degenerate grid skips straight to the output register.
// The result waits in an output register, so the next transaction is taken while
// it is unread. The memories have no reset; entries must be written before use.
module voxel_field_trilinear_sampler #(
  parameter int MAX_CELLS = 262144,
  parameter int MAX_DIM   = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // linear_index, write_value, pos_x, pos_y, pos_z, zero pad
  input  logic [135:0] s_axis_tdata,
  // op, field_sel
  input  logic [3:0]   s_axis_tuser,
  // results
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sky_view, wall_perm, indoorness
  output logic [47:0]  m_axis_tdata,
  // inside_res
  output logic [0:0]   m_axis_tuser
);

  localparam int AW  = $clog2(MAX_CELLS);
  localparam int CIW = vfts_pkg::CIW;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_MUL  = 9'b000000010,
    ST_CHK  = 9'b000000100,
    ST_IDX  = 9'b000001000,
    ST_READ = 9'b000010000,
    ST_LERP = 9'b000100000,
    ST_RD1  = 9'b001000000,
    ST_RD2  = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] cnt_q, cnt_d;

  // Configuration registers
  logic [6:0]  dim_x_q, dim_y_q, dim_z_q;
  logic [23:0] inv_q;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_x_q <= 7'd0;
      dim_y_q <= 7'd0;
      dim_z_q <= 7'd0;
      inv_q   <= 24'd167772;
    end else if (cfg_we) begin
      unique case (vfts_pkg::reg_e'(paddr[3:2]))
        vfts_pkg::REG_DIM_X: dim_x_q <= pwdata[6:0];
        vfts_pkg::REG_DIM_Y: dim_y_q <= pwdata[6:0];
        vfts_pkg::REG_DIM_Z: dim_z_q <= pwdata[6:0];
        vfts_pkg::REG_INV:   inv_q   <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (vfts_pkg::reg_e'(paddr[3:2]))
      vfts_pkg::REG_DIM_X: prdata = {25'd0, dim_x_q};
      vfts_pkg::REG_DIM_Y: prdata = {25'd0, dim_y_q};
      vfts_pkg::REG_DIM_Z: prdata = {25'd0, dim_z_q};
      vfts_pkg::REG_INV:   prdata = {8'd0, inv_q};
      default:             prdata = 32'd0;
    endcase
  end

  // Clamp dimensions to MAX_DIM
  logic [6:0] dx, dy, dz;
  always_comb begin
    dx = (32'(dim_x_q) > 32'(MAX_DIM)) ? 7'(MAX_DIM) : dim_x_q;
    dy = (32'(dim_y_q) > 32'(MAX_DIM)) ? 7'(MAX_DIM) : dim_y_q;
    dz = (32'(dim_z_q) > 32'(MAX_DIM)) ? 7'(MAX_DIM) : dim_z_q;
  end

  // Input transaction fields
  logic              acc_in;
  vfts_pkg::op_e     in_op;
  logic [1:0]        in_sel;
  logic [17:0]       in_idx;
  logic [15:0]       in_val;
  logic              in_idx_ok;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc_in        = s_axis_tvalid & s_axis_tready;
  assign in_op         = vfts_pkg::op_e'(s_axis_tuser[1:0]);
  assign in_sel        = s_axis_tuser[3:2];
  assign in_idx        = s_axis_tdata[17:0];
  assign in_val        = s_axis_tdata[33:18];
  assign in_idx_ok     = (32'(in_idx) < 32'(MAX_CELLS));

  // Item payload registers
  logic signed [31:0] pos_q [3];
  logic [17:0]        idx_q;
  logic [23:0]        base_q [3];
  logic [15:0]        frac_q [3];
  logic [14:0]        t_q;
  logic [13:0]        dxdy_q;
  logic [CIW-1:0]     base_idx_q;
  logic               oob_q;
  logic               use_lerp_q;
  logic [15:0]        st_sky_q, st_wall_q, st_indoor_q;
  logic               st_inside_q;

  // Shared position multiplier
  logic signed [31:0] mul_pos;
  logic signed [56:0] prod;
  always_comb begin
    case (cnt_q[1:0])
      2'd0:    mul_pos = pos_q[0];
      2'd1:    mul_pos = pos_q[1];
      default: mul_pos = pos_q[2];
    endcase
  end
  assign prod = mul_pos * $signed({1'b0, inv_q});

  // Range check of the base cell
  logic ax_ok [3];
  logic [6:0] dsel [3];
  logic grid_ok, cell_ok;
  assign dsel[0] = dx;
  assign dsel[1] = dy;
  assign dsel[2] = dz;
  for (genvar a = 0; a < 3; a++) begin : g_ax
    assign ax_ok[a] = !base_q[a][23] &&
                      ({1'b0, base_q[a]} + 25'd1 < {18'd0, dsel[a]});
  end
  assign grid_ok = (dx > 7'd1) && (dy > 7'd1) && (dz > 7'd1) && (inv_q != 24'd0);
  assign cell_ok = ax_ok[0] && ax_ok[1] && ax_ok[2];

  // Corner addressing
  logic [CIW-1:0] corner_idx;
  logic           oob_d;
  assign corner_idx = base_idx_q + CIW'(cnt_q[0])
                    + (cnt_q[1] ? CIW'(dx) : CIW'(0))
                    + (cnt_q[2] ? CIW'(dxdy_q) : CIW'(0));
  assign oob_d = (32'(corner_idx) >= 32'(MAX_CELLS));

  // Memories
  logic          mem_we;
  logic [15:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   rd_sky, rd_wall, rd_indoor;

  assign mem_we    = acc_in && (in_op == vfts_pkg::OP_WRITE) && in_idx_ok &&
                     (in_sel != vfts_pkg::FS_NONE);
  assign mem_wdata = (in_val > vfts_pkg::ONE_Q15) ? vfts_pkg::ONE_Q15 : in_val;
  assign mem_raddr = (state_q == ST_IDLE) ? AW'(in_idx) : AW'(corner_idx);

  vfts_mem #(
    .DEPTH (MAX_CELLS),
    .AW    (AW)
  ) u_mem (
    .clk_i       (clk_i),
    .we_i        (mem_we),
    .wsel_i      (in_sel),
    .waddr_i     (AW'(in_idx)),
    .wdata_i     (mem_wdata),
    .raddr_i     (mem_raddr),
    .rd_sky_o    (rd_sky),
    .rd_wall_o   (rd_wall),
    .rd_indoor_o (rd_indoor)
  );

  // Lerp step controls
  vfts_pkg::lerp_ctl_t lctl;
  always_comb begin
    lctl.cap_even = (state_q == ST_READ) && cnt_q[0];
    lctl.x_en     = (state_q == ST_READ) && !cnt_q[0] && (cnt_q != 4'd0);
    lctl.y0_en    = (state_q == ST_LERP) && (cnt_q == 4'd0);
    lctl.y1_en    = (state_q == ST_LERP) && (cnt_q == 4'd1);
    lctl.z_en     = (state_q == ST_LERP) && (cnt_q == 4'd2);
  end

  logic [15:0] l_sky, l_wall, l_indoor;

  vfts_lerp u_lerp_sky (
    .clk_i (clk_i), .ctl_i (lctl), .din_i (rd_sky), .zero_i (oob_q),
    .fx_i (frac_q[0]), .fy_i (frac_q[1]), .fz_i (frac_q[2]), .res_o (l_sky)
  );
  vfts_lerp u_lerp_wall (
    .clk_i (clk_i), .ctl_i (lctl), .din_i (rd_wall), .zero_i (oob_q),
    .fx_i (frac_q[0]), .fy_i (frac_q[1]), .fz_i (frac_q[2]), .res_o (l_wall)
  );
  vfts_lerp u_lerp_indoor (
    .clk_i (clk_i), .ctl_i (lctl), .din_i (rd_indoor), .zero_i (oob_q),
    .fx_i (frac_q[0]), .fy_i (frac_q[1]), .fz_i (frac_q[2]), .res_o (l_indoor)
  );

  // Output register
  logic        out_free;
  logic        out_valid_q;
  logic [47:0] out_data_q;
  logic        out_inside_q;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_inside_q;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = 4'd0;
        if (acc_in && in_op == vfts_pkg::OP_SAMPLE) begin
          state_d = ST_MUL;
        end else if (acc_in && in_op == vfts_pkg::OP_READ) begin
          state_d = ST_RD1;
        end
      end
      ST_MUL: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd2) begin
          state_d = ST_CHK;
          cnt_d   = 4'd0;
        end
      end
      ST_CHK:  state_d = (grid_ok && cell_ok) ? ST_IDX : ST_DONE;
      ST_IDX:  state_d = ST_READ;
      ST_READ: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd8) begin
          state_d = ST_LERP;
          cnt_d   = 4'd0;
        end
      end
      ST_LERP: begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd2) begin
          state_d = ST_DONE;
        end
      end
      ST_RD1:  state_d = ST_RD2;
      ST_RD2:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        idx_q    <= in_idx;
        pos_q[0] <= s_axis_tdata[65:34];
        pos_q[1] <= s_axis_tdata[97:66];
        pos_q[2] <= s_axis_tdata[129:98];
      end
      ST_MUL: begin
        case (cnt_q[1:0])
          2'd0: begin base_q[0] <= prod[55:32]; frac_q[0] <= prod[31:16]; end
          2'd1: begin base_q[1] <= prod[55:32]; frac_q[1] <= prod[31:16]; end
          default: begin base_q[2] <= prod[55:32]; frac_q[2] <= prod[31:16]; end
        endcase
      end
      ST_CHK: begin
        t_q        <= 15'(base_q[2][6:0] * dy) + 15'(base_q[1][6:0]);
        dxdy_q     <= 14'(dx * dy);
        use_lerp_q <= grid_ok && cell_ok;
        st_sky_q    <= 16'd0;
        st_wall_q   <= vfts_pkg::ONE_Q15;
        st_indoor_q <= 16'd0;
        st_inside_q <= grid_ok && cell_ok;
      end
      ST_IDX: begin
        base_idx_q <= CIW'(t_q * dx) + CIW'(base_q[0][6:0]);
      end
      ST_READ: begin
        oob_q <= oob_d;
      end
      ST_RD1: begin
        dxdy_q      <= 14'(dx * dy);
        use_lerp_q  <= 1'b0;
        st_sky_q    <= rd_sky;
        st_wall_q   <= rd_wall;
        st_indoor_q <= rd_indoor;
      end
      ST_RD2: begin
        if ((21'(idx_q) < 21'(dxdy_q * dz)) && (32'(idx_q) < 32'(MAX_CELLS))) begin
          st_inside_q <= 1'b1;
        end else begin
          st_sky_q    <= 16'd0;
          st_wall_q   <= vfts_pkg::ONE_Q15;
          st_indoor_q <= 16'd0;
          st_inside_q <= 1'b0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_q   <= use_lerp_q ? {l_indoor, l_wall, l_sky}
                                     : {st_indoor_q, st_wall_q, st_sky_q};
          out_inside_q <= st_inside_q;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  // A result outside the grid carries the defaults
  a_defaults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tdata[15:0] == 16'd0 && m_axis_tdata[31:16] == vfts_pkg::ONE_Q15 &&
       m_axis_tdata[47:32] == 16'd0))
    else $error("outside result without defaults");

  // Every result stays within 1.0
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= vfts_pkg::ONE_Q15 &&
                       m_axis_tdata[31:16] <= vfts_pkg::ONE_Q15 &&
                       m_axis_tdata[47:32] <= vfts_pkg::ONE_Q15))
    else $error("result above 1.0");

  // An accepted sample starts the multiplier sequence
  a_sample_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_in && in_op == vfts_pkg::OP_SAMPLE) |=> (state_q == ST_MUL && cnt_q == 4'd0))
    else $error("sample not started");
`endif

endmodule
